>>> hw/rtl/zfu_pkg.sv
// Package for the Zba zero-extend pair fusion unit.
// Op kind codes, decoded instruction and fusion result types.
// No dependencies.
package zfu_pkg;

	localparam int unsigned OP_W  = 5;
	localparam int unsigned REG_W = 5;
	localparam int unsigned IMM_W = 12;

	localparam logic [OP_W-1:0] OP_OTHER  = 5'd0;
	localparam logic [OP_W-1:0] OP_LWU    = 5'd1;
	localparam logic [OP_W-1:0] OP_LBU    = 5'd2;
	localparam logic [OP_W-1:0] OP_LHU    = 5'd3;
	localparam logic [OP_W-1:0] OP_ZEXTH  = 5'd4;
	localparam logic [OP_W-1:0] OP_ADDUW  = 5'd5;
	localparam logic [OP_W-1:0] OP_ANDI   = 5'd6;
	localparam logic [OP_W-1:0] OP_SRLI   = 5'd7;
	localparam logic [OP_W-1:0] OP_SLLI   = 5'd8;
	localparam logic [OP_W-1:0] OP_ADD    = 5'd9;
	localparam logic [OP_W-1:0] OP_SH1ADD = 5'd10;
	localparam logic [OP_W-1:0] OP_SH3ADD = 5'd12;
	localparam logic [OP_W-1:0] OP_SLLIUW = 5'd16;

	// shNadd -> shNadd.uw code offset
	localparam logic [OP_W-1:0] SH_TO_UW = 5'd3;

	localparam logic [REG_W-1:0] X0 = 5'd0;
	localparam logic [IMM_W-1:0] IMM_WORD = 12'd32;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [REG_W-1:0] rd;
		logic [REG_W-1:0] rs1;
		logic [REG_W-1:0] rs2;
		logic [IMM_W-1:0] imm;
	} insn_t;

	typedef struct packed {
		logic             fused;
		logic [OP_W-1:0]  op;
		logic [REG_W-1:0] rd;
		logic [REG_W-1:0] rs1;
		logic [REG_W-1:0] rs2;
		logic [IMM_W-1:0] imm;
	} fuse_res_t;

endpackage

>>> hw/rtl/zfu_match.sv
// Pattern matcher for the Zba zero-extend pair fusion unit.
// Pure combinational: tries zext.w, redundant zext.w and .uw folding in order.
// Depends on zfu_pkg.
module zfu_match (
	input  logic              enable,
	input  zfu_pkg::insn_t    first,
	input  zfu_pkg::insn_t    second,
	output zfu_pkg::fuse_res_t res
);
	import zfu_pkg::*;

	logic clean;
	logic p1_hit;
	logic p2_hit;
	logic p3_base;
	logic add_hit;
	logic [REG_W-1:0] add_other;
	logic sh_hit;
	logic slli_hit;
	logic is_shadd;

	always_comb begin
		case (first.op)
			OP_LWU, OP_LBU, OP_LHU, OP_ZEXTH: clean = 1'b1;
			OP_ADDUW: clean = (first.rs2 == X0);
			OP_ANDI:  clean = !first.imm[IMM_W-1];
			// signed imm >= 32
			OP_SRLI:  clean = !first.imm[IMM_W-1] && (first.imm[IMM_W-2:5] != '0);
			default:  clean = 1'b0;
		endcase
	end

	assign p1_hit = (first.op == OP_SLLI) && (first.imm == IMM_WORD)
		&& (second.op == OP_SRLI) && (second.rd == first.rd)
		&& (second.rs1 == first.rd) && (second.imm == IMM_WORD) && (first.rd != X0);

	assign p2_hit = (second.op == OP_ADDUW) && (second.rs1 == second.rd)
		&& (second.rs2 == X0) && (second.rd != X0) && (first.rd == second.rd) && clean;

	assign p3_base = (first.op == OP_ADDUW) && (first.rs2 == X0)
		&& (first.rd != X0) && (second.rd == first.rd);

	always_comb begin
		add_other = second.rs2;
		if (second.rs1 != first.rd)
			add_other = second.rs1;
	end

	assign add_hit = (second.op == OP_ADD)
		&& ((second.rs1 == first.rd) || (second.rs2 == first.rd))
		&& (add_other != first.rd);

	assign is_shadd = (second.op >= OP_SH1ADD) && (second.op <= OP_SH3ADD);
	assign sh_hit = is_shadd && (second.rs1 == first.rd) && (second.rs2 != first.rd);

	// signed imm >= 1
	assign slli_hit = (second.op == OP_SLLI) && (second.rs1 == first.rd)
		&& !second.imm[IMM_W-1] && (second.imm != '0);

	always_comb begin
		res = '0;
		if (enable) begin
			if (p1_hit) begin
				res = '{1'b1, OP_ADDUW, first.rd, first.rs1, X0, '0};
			end else if (p2_hit) begin
				res = '{1'b1, first.op, first.rd, first.rs1, first.rs2, first.imm};
			end else if (p3_base && add_hit) begin
				res = '{1'b1, OP_ADDUW, first.rd, first.rs1, add_other, '0};
			end else if (p3_base && sh_hit) begin
				res = '{1'b1, OP_W'(second.op + SH_TO_UW), first.rd, first.rs1,
					second.rs2, '0};
			end else if (p3_base && slli_hit) begin
				res = '{1'b1, OP_SLLIUW, first.rd, first.rs1, X0, second.imm};
			end
		end
	end

endmodule

>>> hw/rtl/rv64_zba_zext_pair_fusion_unit.sv
// Top level of the Zba zero-extend pair fusion unit.
// Input register, zfu_match and result register. Depends on zfu_pkg, zfu_match.
//
// Usage:
//   Input: drive first_* / second_* with a decoded instruction pair and pulse
//   start. A pair transfers at a rising edge with start high and busy low.
//   busy is always low: one pair is taken every cycle, back to back.
//   Output: each accepted pair yields exactly one result, shown for one cycle
//   with done high. fused low means no replacement and all result fields 0.
//   A pair transferred at an edge goes through the input register and then the
//   result register; done is high while the result register holds it, and the
//   result transfers at the edge that ends the done cycle.
//   Throughput: one pair per cycle, set by the single pass of match logic.
//   Config: fusion_enable transfers when cfg_valid and cfg_ready are high;
//   cfg_ready is always high. Write it only while no pair is in flight.
//   Reset (arst_n low) clears the pipeline valid bits and sets fusion_enable.
//   The receiver cannot stall; results must be taken on the done cycle.
module rv64_zba_zext_pair_fusion_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [zfu_pkg::OP_W-1:0]         first_op,
	input  logic [zfu_pkg::REG_W-1:0]        first_rd,
	input  logic [zfu_pkg::REG_W-1:0]        first_rs1,
	input  logic [zfu_pkg::REG_W-1:0]        first_rs2,
	input  logic signed [zfu_pkg::IMM_W-1:0] first_imm,
	input  logic [zfu_pkg::OP_W-1:0]         second_op,
	input  logic [zfu_pkg::REG_W-1:0]        second_rd,
	input  logic [zfu_pkg::REG_W-1:0]        second_rs1,
	input  logic [zfu_pkg::REG_W-1:0]        second_rs2,
	input  logic signed [zfu_pkg::IMM_W-1:0] second_imm,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	output logic                             done,
	output logic                             fused,
	output logic [zfu_pkg::OP_W-1:0]         out_op,
	output logic [zfu_pkg::REG_W-1:0]        out_rd,
	output logic [zfu_pkg::REG_W-1:0]        out_rs1,
	output logic [zfu_pkg::REG_W-1:0]        out_rs2,
	output logic signed [zfu_pkg::IMM_W-1:0] out_imm
);
	import zfu_pkg::*;

	logic      fusion_enable_q;
	logic      valid_s1;
	logic      valid_s2;
	insn_t     first_s1;
	insn_t     second_s1;
	fuse_res_t res_comb;
	fuse_res_t res_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fusion_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			fusion_enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			first_s1  <= '{first_op, first_rd, first_rs1, first_rs2, first_imm};
			second_s1 <= '{second_op, second_rd, second_rs1, second_rs2, second_imm};
		end
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	zfu_match u_match (
		.enable (fusion_enable_q),
		.first  (first_s1),
		.second (second_s1),
		.res    (res_comb)
	);

	assign done    = valid_s2;
	assign fused   = res_s2.fused;
	assign out_op  = res_s2.op;
	assign out_rd  = res_s2.rd;
	assign out_rs1 = res_s2.rs1;
	assign out_rs2 = res_s2.rs2;
	assign out_imm = res_s2.imm;

endmodule

>>> hw/rtl/zfu_checker.sv
// Port-level checker for the Zba zero-extend pair fusion unit.
// Bound to rv64_zba_zext_pair_fusion_unit; depends on zfu_pkg.
module zfu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic                             fused,
	input logic [zfu_pkg::OP_W-1:0]         out_op,
	input logic [zfu_pkg::REG_W-1:0]        out_rd,
	input logic [zfu_pkg::REG_W-1:0]        out_rs1,
	input logic [zfu_pkg::REG_W-1:0]        out_rs2,
	input logic signed [zfu_pkg::IMM_W-1:0] out_imm
);
	import zfu_pkg::*;

	// every transfer in yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("missing result for accepted pair");

	// no result without a matching transfer in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted pair");

	a_nofuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !fused |-> out_op == OP_OTHER && out_rd == X0 && out_rs1 == X0
			&& out_rs2 == X0 && out_imm == '0)
		else $error("unfused result carries nonzero fields");

	// every replacement writes a real register
	a_fuse_rd: assert property (@(posedge clk) disable iff (!arst_n)
		done && fused |-> out_rd != X0 && out_op != OP_OTHER)
		else $error("fused result with x0 destination or no op");

endmodule

bind rv64_zba_zext_pair_fusion_unit zfu_checker u_zfu_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.fused   (fused),
	.out_op  (out_op),
	.out_rd  (out_rd),
	.out_rs1 (out_rs1),
	.out_rs2 (out_rs2),
	.out_imm (out_imm)
);

>>> bench/rv64_zba_zext_pair_fusion_unit_tb.sv
// Testbench for rv64_zba_zext_pair_fusion_unit: directed and random instruction pairs,
// each result checked against an in-bench fusion predictor.
// Depends on zfu_pkg and the fusion unit RTL.
`timescale 1ns / 1ps

module rv64_zba_zext_pair_fusion_unit_tb;
	import zfu_pkg::*;

	localparam logic [OP_W-1:0] OP_SH2ADD   = OP_SH1ADD + 5'd1;
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 5'd13;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 5'd31;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [OP_W-1:0]  first_op = '0, second_op = '0;
	logic [REG_W-1:0] first_rd = '0, first_rs1 = '0, first_rs2 = '0;
	logic [REG_W-1:0] second_rd = '0, second_rs1 = '0, second_rs2 = '0;
	logic [IMM_W-1:0] first_imm = '0, second_imm = '0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_data = 1'b0;
	logic             done;
	logic             fused;
	logic [OP_W-1:0]  out_op;
	logic [REG_W-1:0] out_rd, out_rs1, out_rs2;
	logic [IMM_W-1:0] out_imm;

	fuse_res_t pending_fusions[$];
	logic      fusion_on = 1'b1;
	int        n_mismatch = 0;
	int        sender_idle_pct = 0;

	rv64_zba_zext_pair_fusion_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_op(first_op),
		.first_rd(first_rd),
		.first_rs1(first_rs1),
		.first_rs2(first_rs2),
		.first_imm(first_imm),
		.second_op(second_op),
		.second_rd(second_rd),
		.second_rs1(second_rs1),
		.second_rs2(second_rs2),
		.second_imm(second_imm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.fused(fused),
		.out_op(out_op),
		.out_rd(out_rd),
		.out_rs1(out_rs1),
		.out_rs2(out_rs2),
		.out_imm(out_imm)
	);

	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("rv64_zba_zext_pair_fusion_unit regression: fail");
		$finish;
	end

	function automatic insn_t mk_insn(logic [OP_W-1:0] op, logic [REG_W-1:0] rd,
			logic [REG_W-1:0] rs1, logic [REG_W-1:0] rs2, logic [IMM_W-1:0] imm);
		insn_t i;
		i.op  = op;
		i.rd  = rd;
		i.rs1 = rs1;
		i.rs2 = rs2;
		i.imm = imm;
		return i;
	endfunction

	// expected replacement for one pair
	function automatic fuse_res_t fuse_pair(insn_t a, insn_t b, logic en);
		fuse_res_t        r;
		logic [REG_W-1:0] other;
		logic             clean;
		r = '0;
		if (!en)
			return r;
		if (a.op == OP_SLLI && a.imm == IMM_WORD && b.op == OP_SRLI && b.rd == a.rd &&
				b.rs1 == a.rd && b.imm == IMM_WORD && a.rd != X0)
			return {1'b1, OP_ADDUW, a.rd, a.rs1, X0, 12'd0};
		case (a.op)
			OP_LWU, OP_LBU, OP_LHU, OP_ZEXTH: clean = 1'b1;
			OP_ADDUW: clean = (a.rs2 == X0);
			OP_ANDI:  clean = !a.imm[IMM_W-1];
			OP_SRLI:  clean = ($signed(a.imm) >= 32);
			default:  clean = 1'b0;
		endcase
		if (b.op == OP_ADDUW && b.rs1 == b.rd && b.rs2 == X0 && b.rd != X0 &&
				a.rd == b.rd && clean)
			return {1'b1, a};
		if (a.op != OP_ADDUW || a.rs2 != X0 || a.rd == X0 || b.rd != a.rd)
			return r;
		if (b.op == OP_ADD) begin
			if (b.rs1 == a.rd)
				other = b.rs2;
			else if (b.rs2 == a.rd)
				other = b.rs1;
			else
				return r;
			if (other == a.rd)
				return r;
			return {1'b1, OP_ADDUW, a.rd, a.rs1, other, 12'd0};
		end
		if (b.op >= OP_SH1ADD && b.op <= OP_SH3ADD) begin
			if (b.rs1 != a.rd || b.rs2 == a.rd)
				return r;
			return {1'b1, b.op + SH_TO_UW, a.rd, a.rs1, b.rs2, 12'd0};
		end
		if (b.op == OP_SLLI && b.rs1 == a.rd && $signed(b.imm) >= 1)
			return {1'b1, OP_SLLIUW, a.rd, a.rs1, X0, b.imm};
		return r;
	endfunction

	// prediction on each pair transfer, check on each done strobe
	always @(posedge clk) begin
		fuse_res_t got, want;
		if (cfg_valid && cfg_ready)
			fusion_on = cfg_data;
		if (start && !busy)
			pending_fusions.push_back(fuse_pair(
				{first_op, first_rd, first_rs1, first_rs2, first_imm},
				{second_op, second_rd, second_rs1, second_rs2, second_imm}, fusion_on));
		if (done) begin
			got = {fused, out_op, out_rd, out_rs1, out_rs2, out_imm};
			if (pending_fusions.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result at %0t: fused=%0d op=%0d", $realtime,
						fused, out_op);
			end else begin
				want = pending_fusions.pop_front();
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("mismatch at %0t: exp fused=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d",
							$realtime, want.fused, want.op, want.rd, want.rs1, want.rs2,
							$signed(want.imm));
						$display("  got fused=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d",
							got.fused, got.op, got.rd, got.rs1, got.rs2, $signed(got.imm));
					end
				end
			end
		end
	end

	task automatic send_pair(input insn_t a, input insn_t b);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		first_op   <= a.op;
		first_rd   <= a.rd;
		first_rs1  <= a.rs1;
		first_rs2  <= a.rs2;
		first_imm  <= a.imm;
		second_op  <= b.op;
		second_rd  <= b.rd;
		second_rs1 <= b.rs1;
		second_rs2 <= b.rs2;
		second_imm <= b.imm;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_idle();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (pending_fusions.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_fusion_enable(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [REG_W-1:0] pick_reg();
		if ($urandom_range(7) == 0)
			return X0;
		return REG_W'($urandom_range(31));
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		if ($urandom_range(9) == 0)
			return OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
		return OP_W'($urandom_range(OP_SH3ADD, OP_OTHER));
	endfunction

	function automatic logic [IMM_W-1:0] pick_imm();
		case ($urandom_range(5))
			0, 1: return IMM_WORD;
			2: return IMM_W'($urandom_range(63));
			3: begin
				case ($urandom_range(3))
					0: return 12'h7FF;
					1: return 12'h800;
					2: return 12'hFFF;
					default: return 12'h000;
				endcase
			end
			default: return IMM_W'($urandom);
		endcase
	endfunction

	// mostly well-formed fusion candidates with random content, some noise
	task automatic make_pair(output insn_t a, output insn_t b);
		logic [REG_W-1:0] t, r;
		logic [OP_W-1:0]  prod_op;
		t = pick_reg();
		r = pick_reg();
		a = mk_insn(pick_op(), pick_reg(), pick_reg(), pick_reg(), pick_imm());
		b = mk_insn(pick_op(), pick_reg(), pick_reg(), pick_reg(), pick_imm());
		case ($urandom_range(9))
			0, 1: begin
				a = mk_insn(OP_SLLI, t, r, pick_reg(), IMM_WORD);
				b = mk_insn(OP_SRLI, t, t, pick_reg(), IMM_WORD);
			end
			2, 3, 4: begin
				case ($urandom_range(6))
					0: prod_op = OP_LWU;
					1: prod_op = OP_LBU;
					2: prod_op = OP_LHU;
					3: prod_op = OP_ZEXTH;
					4: prod_op = OP_ADDUW;
					5: prod_op = OP_ANDI;
					default: prod_op = OP_SRLI;
				endcase
				a = mk_insn(prod_op, t, r, ($urandom_range(3) == 0) ? pick_reg() : X0,
					pick_imm());
				b = mk_insn(OP_ADDUW, t, t, X0, pick_imm());
			end
			5, 6, 7: begin
				a = mk_insn(OP_ADDUW, t, r, X0, pick_imm());
				case ($urandom_range(4))
					0: b = mk_insn(OP_ADD, t, t, pick_reg(), pick_imm());
					1: b = mk_insn(OP_ADD, t, pick_reg(), t, pick_imm());
					2, 3: b = mk_insn(OP_SH1ADD + OP_W'($urandom_range(2)), t, t, pick_reg(),
						pick_imm());
					default: b = mk_insn(OP_SLLI, t, t, pick_reg(), pick_imm());
				endcase
			end
			default: ;
		endcase
		// broken sequence: disturb one field
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(5))
				0: a.op = pick_op();
				1: b.op = pick_op();
				2: b.rd = pick_reg();
				3: b.rs1 = pick_reg();
				4: a.imm = pick_imm();
				default: b.rs2 = pick_reg();
			endcase
		end
	endtask

	task automatic test_directed_patterns();
		sender_idle_pct = 13;
		// slli/srli by 32 -> zext.w
		send_pair(mk_insn(OP_SLLI, 5'd5, 5'd7, X0, IMM_WORD),
			mk_insn(OP_SRLI, 5'd5, 5'd5, 5'd31, IMM_WORD));
		send_pair(mk_insn(OP_SLLI, X0, 5'd7, X0, IMM_WORD),
			mk_insn(OP_SRLI, X0, X0, X0, IMM_WORD));
		send_pair(mk_insn(OP_SLLI, 5'd5, 5'd7, X0, 12'd31),
			mk_insn(OP_SRLI, 5'd5, 5'd5, X0, IMM_WORD));
		// clean producer then redundant zext.w
		send_pair(mk_insn(OP_LWU, 5'd9, 5'd3, X0, 12'h7FF), mk_insn(OP_ADDUW, 5'd9, 5'd9, X0, 12'd0));
		send_pair(mk_insn(OP_LBU, 5'd31, 5'd31, 5'd31, 12'h800),
			mk_insn(OP_ADDUW, 5'd31, 5'd31, X0, 12'hFFF));
		send_pair(mk_insn(OP_LHU, 5'd1, 5'd2, X0, 12'd4), mk_insn(OP_ADDUW, 5'd1, 5'd1, X0, 12'd0));
		send_pair(mk_insn(OP_ZEXTH, 5'd4, 5'd6, X0, 12'd0), mk_insn(OP_ADDUW, 5'd4, 5'd4, X0, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd8, 5'd2, X0, 12'd0), mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_ANDI, 5'd8, 5'd2, 5'd3, 12'h7FF),
			mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_ANDI, 5'd8, 5'd2, X0, 12'h800), mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_SRLI, 5'd8, 5'd2, X0, IMM_WORD), mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_SRLI, 5'd8, 5'd2, X0, 12'd31), mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_SRLI, 5'd8, 5'd2, X0, 12'hFFF), mk_insn(OP_ADDUW, 5'd8, 5'd8, X0, 12'd0));
		send_pair(mk_insn(OP_LWU, X0, 5'd2, X0, 12'd0), mk_insn(OP_ADDUW, X0, X0, X0, 12'd0));
		// zext.w feeding a consumer
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_ADD, 5'd10, 5'd10, 5'd12, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_ADD, 5'd10, 5'd12, 5'd10, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_ADD, 5'd10, 5'd10, 5'd10, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0),
			mk_insn(OP_SH1ADD, 5'd10, 5'd10, 5'd31, 12'h7FF));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SH2ADD, 5'd10, 5'd10, X0, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SH3ADD, 5'd10, 5'd10, 5'd3, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SH3ADD, 5'd10, 5'd10, 5'd10, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SLLI, 5'd10, 5'd10, X0, 12'd1));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SLLI, 5'd10, 5'd10, X0, 12'd0));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SLLI, 5'd10, 5'd10, X0, 12'h7FF));
		send_pair(mk_insn(OP_ADDUW, 5'd10, 5'd11, X0, 12'd0), mk_insn(OP_SLLI, 5'd10, 5'd10, X0, 12'h800));
		// undefined op codes act as "other"; all-ones and all-zero fields
		send_pair(mk_insn(OP_UNDEF_LO, 5'd3, 5'd1, X0, 12'd0), mk_insn(OP_ADDUW, 5'd3, 5'd3, X0, 12'd0));
		send_pair(mk_insn(OP_UNDEF_HI, 5'd31, 5'd31, 5'd31, 12'hFFF),
			mk_insn(OP_UNDEF_HI, 5'd31, 5'd31, 5'd31, 12'hFFF));
		send_pair(mk_insn(OP_OTHER, X0, X0, X0, 12'd0), mk_insn(OP_OTHER, X0, X0, X0, 12'd0));
		wait_idle();
	endtask

	task automatic test_fusion_disabled(input int n_pairs);
		insn_t a, b;
		write_fusion_enable(1'b0);
		sender_idle_pct = 13;
		for (int i = 0; i < n_pairs; i++) begin
			make_pair(a, b);
			send_pair(a, b);
		end
		wait_idle();
		write_fusion_enable(1'b1);
	endtask

	task automatic test_random_traffic(input int n_pairs, input int idle_pct);
		insn_t a, b;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_pairs; i++) begin
			// hold off once mid-phase until the pipeline is empty
			if (i == n_pairs / 2)
				wait_idle();
			make_pair(a, b);
			send_pair(a, b);
		end
		wait_idle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_patterns();
		test_fusion_disabled(100);
		test_random_traffic(350, 13);
		test_random_traffic(350, 63);
		write_fusion_enable(1'b1);
		test_random_traffic(350, 0);
		if (n_mismatch == 0 && pending_fusions.size() == 0)
			$display("rv64_zba_zext_pair_fusion_unit regression: pass");
		else
			$display("rv64_zba_zext_pair_fusion_unit regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/zfu_pkg.sv
hw/rtl/zfu_match.sv
hw/rtl/rv64_zba_zext_pair_fusion_unit.sv
hw/rtl/zfu_checker.sv
bench/rv64_zba_zext_pair_fusion_unit_tb.sv
